[rtl/ordered_deque_with_priority_insert_unit_macros.svh]
// Assertion macros for the ordered deque with priority insert unit.
// Used by the checker; depends on nothing else.
`ifndef ORDERED_DEQUE_WITH_PRIORITY_INSERT_UNIT_MACROS_SVH
`define ORDERED_DEQUE_WITH_PRIORITY_INSERT_UNIT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ODPI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ODPI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/odpi_pkg.sv]
// Shared types and constants of the ordered deque with priority insert unit.
// Used by the cell, the top level and the checker; depends on nothing.
package odpi_pkg;

	localparam int DEPTH_DEF          = 16;
	localparam int VALUE_WIDTH_DEF    = 32;
	localparam int PRIORITY_WIDTH_DEF = 16;

	typedef enum logic [2:0] {
		OP_APPEND  = 3'd0,
		OP_PREPEND = 3'd1,
		OP_INSERT  = 3'd2,
		OP_DEQUEUE = 3'd3,
		OP_DELETE  = 3'd4,
		OP_PEEK    = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [31:0]        item_value;
		logic signed [15:0] priority_req;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] result_value;
		logic [4:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic shift_in;
		logic shift_out;
		logic sel_all;
		logic sel_empty;
		logic sel_pri;
		logic sel_val;
	} cell_ctl_t;

endpackage

[rtl/odpi_cell.sv]
// One entry of the ordered queue: value, priority and the local insert/remove decision.
// Depends on odpi_pkg for the broadcast control struct.
module odpi_cell #(
	parameter int VALUE_WIDTH    = odpi_pkg::VALUE_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = odpi_pkg::PRIORITY_WIDTH_DEF,
	parameter int OCC_WIDTH      = 5,
	parameter int INDEX          = 0
) (
	input  logic                             clk,
	input  odpi_pkg::cell_ctl_t              ctl,
	input  logic [OCC_WIDTH-1:0]             occ,
	input  logic [VALUE_WIDTH-1:0]           key_value,
	input  logic signed [PRIORITY_WIDTH-1:0] key_pri,
	input  logic [VALUE_WIDTH-1:0]           left_value,
	input  logic signed [PRIORITY_WIDTH-1:0] left_pri,
	input  logic [VALUE_WIDTH-1:0]           right_value,
	input  logic signed [PRIORITY_WIDTH-1:0] right_pri,
	input  logic                             hit_in,
	output logic                             hit_out,
	output logic                             tail_ge,
	output logic [VALUE_WIDTH-1:0]           value,
	output logic signed [PRIORITY_WIDTH-1:0] pri
);

	localparam logic [OCC_WIDTH:0] HERE = (OCC_WIDTH + 1)'(INDEX);
	localparam logic [OCC_WIDTH:0] NEXT = (OCC_WIDTH + 1)'(INDEX + 1);

	logic [VALUE_WIDTH-1:0]           value_q;
	logic signed [PRIORITY_WIDTH-1:0] pri_q;
	logic                             valid;
	logic                             next_valid;
	logic                             hit_here;

	assign valid      = {1'b0, occ} > HERE;
	assign next_valid = {1'b0, occ} > NEXT;

	assign hit_here = ctl.sel_all
		| (ctl.sel_empty & ~valid)
		| (ctl.sel_pri & valid & (key_pri <= pri_q))
		| (ctl.sel_val & valid & (key_value == value_q));

	assign hit_out = hit_in | hit_here;
	assign tail_ge = valid & ~next_valid & (key_pri >= pri_q);
	assign value   = value_q;
	assign pri     = pri_q;

	always_ff @(posedge clk) begin
		if (ctl.shift_in) begin
			if (hit_in) begin
				value_q <= left_value;
				pri_q   <= left_pri;
			end else if (hit_here) begin
				value_q <= key_value;
				pri_q   <= key_pri;
			end
		end else if (ctl.shift_out && hit_out) begin
			value_q <= right_value;
			pri_q   <= right_pri;
		end
	end

endmodule

[rtl/ordered_deque_with_priority_insert_unit.sv]
// Top level of the ordered deque with priority insert unit: control, cell row, output stage.
// Depends on odpi_pkg and odpi_cell.
//
// The unit takes one item per clock cycle unless req_stall is high and registers the result
// of each accepted item in the output stage. The entries live in a row of DEPTH cells;
// every operation is broadcast to all cells, each compares its own entry, and a first-hit
// chain through the row decides which cells keep, take the new entry, or take a neighbor's
// entry, all in the same cycle. That chain through the DEPTH cells sets the critical path.
// A two-deep output stage lets the next item enter while a result waits; the request side
// stalls only when both output slots are full. Entries need no clearing after reset.
module ordered_deque_with_priority_insert_unit #(
	parameter int DEPTH          = odpi_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH    = odpi_pkg::VALUE_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = odpi_pkg::PRIORITY_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  odpi_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output odpi_pkg::rsp_t rsp
);

	localparam int OW    = $clog2(DEPTH + 1);
	localparam int VW_IN = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
	localparam logic [OW-1:0] FULL_COUNT = OW'(DEPTH);

	logic [OW-1:0]                    occ_q;
	logic [OW-1:0]                    occ_next;
	logic                             rsp_valid_q;
	logic                             skid_valid_q;
	odpi_pkg::rsp_t                   rsp_q;
	odpi_pkg::rsp_t                   skid_q;
	odpi_pkg::rsp_t                   result;
	odpi_pkg::cell_ctl_t              ctl;
	logic                             accept;
	logic                             out_take;
	logic                             is_empty;
	logic                             is_full;
	logic                             head_le;
	logic                             tail_any;
	logic [VALUE_WIDTH-1:0]           key_value;
	logic signed [PRIORITY_WIDTH-1:0] key_pri;
	logic [VALUE_WIDTH-1:0]           cell_value [DEPTH];
	logic signed [PRIORITY_WIDTH-1:0] cell_pri [DEPTH];
	logic [DEPTH:0]                   hit;
	logic [DEPTH-1:0]                 tail_ge;

	assign accept    = req_valid & ~skid_valid_q;
	assign out_take  = rsp_valid_q & ~rsp_stall;
	assign req_stall = skid_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign key_value = VALUE_WIDTH'(req.item_value[VW_IN-1:0]);
	assign key_pri   = (req.opcode == odpi_pkg::OP_INSERT)
		? $signed(PRIORITY_WIDTH'($unsigned(req.priority_req))) : '0;

	assign is_empty = occ_q == '0;
	assign is_full  = occ_q == FULL_COUNT;
	assign head_le  = key_pri <= cell_pri[0];
	assign tail_any = |tail_ge;
	assign hit[0]   = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0]           left_value;
		logic signed [PRIORITY_WIDTH-1:0] left_pri;
		logic [VALUE_WIDTH-1:0]           right_value;
		logic signed [PRIORITY_WIDTH-1:0] right_pri;

		if (i == 0) begin : g_first
			assign left_value = key_value;
			assign left_pri   = key_pri;
		end else begin : g_inner_l
			assign left_value = cell_value[i-1];
			assign left_pri   = cell_pri[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_value = key_value;
			assign right_pri   = key_pri;
		end else begin : g_inner_r
			assign right_value = cell_value[i+1];
			assign right_pri   = cell_pri[i+1];
		end

		odpi_cell #(
			.VALUE_WIDTH   (VALUE_WIDTH),
			.PRIORITY_WIDTH(PRIORITY_WIDTH),
			.OCC_WIDTH     (OW),
			.INDEX         (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occ        (occ_q),
			.key_value  (key_value),
			.key_pri    (key_pri),
			.left_value (left_value),
			.left_pri   (left_pri),
			.right_value(right_value),
			.right_pri  (right_pri),
			.hit_in     (hit[i]),
			.hit_out    (hit[i+1]),
			.tail_ge    (tail_ge[i]),
			.value      (cell_value[i]),
			.pri        (cell_pri[i])
		);
	end

	always_comb begin
		ctl = '0;
		unique case (req.opcode)
			odpi_pkg::OP_APPEND, odpi_pkg::OP_PREPEND, odpi_pkg::OP_INSERT: begin
				if (!is_full) begin
					ctl.shift_in = 1'b1;
					if (req.opcode == odpi_pkg::OP_APPEND) begin
						ctl.sel_empty = 1'b1;
					end else if (req.opcode == odpi_pkg::OP_PREPEND) begin
						ctl.sel_all = 1'b1;
					end else if (is_empty || head_le) begin
						ctl.sel_all = 1'b1;
					end else if (tail_any) begin
						ctl.sel_empty = 1'b1;
					end else begin
						ctl.sel_pri = 1'b1;
					end
				end
			end
			odpi_pkg::OP_DEQUEUE, odpi_pkg::OP_PEEK: begin
				if (!is_empty && req.opcode == odpi_pkg::OP_DEQUEUE) begin
					ctl.shift_out = 1'b1;
					ctl.sel_all   = 1'b1;
				end
			end
			odpi_pkg::OP_DELETE: begin
				ctl.shift_out = 1'b1;
				ctl.sel_val   = 1'b1;
			end
			default: begin
			end
		endcase
		if (!accept) begin
			ctl.shift_in  = 1'b0;
			ctl.shift_out = 1'b0;
		end
	end

	always_comb begin
		occ_next            = occ_q;
		result.status       = odpi_pkg::ST_OK;
		result.result_value = '0;
		unique case (req.opcode)
			odpi_pkg::OP_APPEND, odpi_pkg::OP_PREPEND, odpi_pkg::OP_INSERT: begin
				if (is_full) begin
					result.status = odpi_pkg::ST_FULL;
				end else begin
					occ_next = occ_q + 1'b1;
				end
			end
			odpi_pkg::OP_DEQUEUE, odpi_pkg::OP_PEEK: begin
				if (is_empty) begin
					result.status = odpi_pkg::ST_EMPTY;
				end else begin
					result.result_value = 32'(cell_value[0]);
					if (req.opcode == odpi_pkg::OP_DEQUEUE) begin
						occ_next = occ_q - 1'b1;
					end
				end
			end
			odpi_pkg::OP_DELETE: begin
				if (hit[DEPTH]) begin
					occ_next = occ_q - 1'b1;
				end else begin
					result.status = odpi_pkg::ST_NOTFOUND;
				end
			end
			default: begin
			end
		endcase
		result.entry_count = 5'(occ_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q        <= '0;
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				occ_q <= occ_next;
				if (!rsp_valid_q || out_take) begin
					rsp_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				rsp_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (!rsp_valid_q || out_take)) begin
			rsp_q <= result;
		end else if (out_take && skid_valid_q) begin
			rsp_q <= skid_q;
		end
		if (accept && rsp_valid_q && !out_take) begin
			skid_q <= result;
		end
	end

endmodule

[rtl/odpi_checker.sv]
// Port-level checks of the ordered deque with priority insert unit, with its bind.
// Depends on odpi_pkg and the assertion macros header.
`include "ordered_deque_with_priority_insert_unit_macros.svh"

module odpi_checker #(
	parameter int DEPTH = odpi_pkg::DEPTH_DEF
) (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input odpi_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input odpi_pkg::rsp_t rsp
);

	localparam logic [4:0] FULL_COUNT = 5'(DEPTH);

	`ODPI_ASSERT_ALWAYS(a_no_rsp_in_reset, clk, !arst_n |-> !rsp_valid, "Result shown during reset.")
	`ODPI_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "Stalled result item changed.")
	`ODPI_ASSERT(a_full_count, clk, arst_n, rsp_valid && rsp.status == odpi_pkg::ST_FULL |-> rsp.entry_count == FULL_COUNT, "Full status without a full queue.")
	`ODPI_ASSERT(a_empty_zero, clk, arst_n, rsp_valid && rsp.status == odpi_pkg::ST_EMPTY |-> rsp.entry_count == 5'd0 && rsp.result_value == 32'd0, "Empty status with entries or a value.")
	`ODPI_ASSERT(a_notfound_zero, clk, arst_n, rsp_valid && rsp.status == odpi_pkg::ST_NOTFOUND |-> rsp.result_value == 32'd0, "Not found status with a value.")

endmodule

bind ordered_deque_with_priority_insert_unit odpi_checker #(.DEPTH(DEPTH)) u_odpi_checker (.*);

[test/ordered_deque_with_priority_insert_unit_tb.sv]
// Self-checking testbench for the ordered deque with priority insert unit.
// Keeps a shadow deque that predicts every response; depends on odpi_pkg and the unit's RTL.
// Directed cases come first, then random traffic under several idle and stall mixes.
module ordered_deque_with_priority_insert_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = odpi_pkg::DEPTH_DEF;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam logic [2:0] OP_RESERVED_6 = 3'd6;
	localparam logic [2:0] OP_RESERVED_7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic req_valid = 1'b0;
	logic req_stall;
	odpi_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	odpi_pkg::rsp_t rsp;

	logic [31:0] shadow_values[$];
	logic signed [15:0] shadow_priorities[$];
	odpi_pkg::rsp_t pending_responses[$];
	int mismatches = 0;
	int sender_idle_pct = 0;
	int rsp_stall_pct = 0;
	int unsigned cycle_count = 0;

	ordered_deque_with_priority_insert_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
	end

	function automatic odpi_pkg::rsp_t deque_apply(odpi_pkg::req_t item);
		odpi_pkg::rsp_t r;
		int pos;
		int count;
		logic signed [15:0] pri;
		logic signed [15:0] placed_pri;
		r.status = odpi_pkg::ST_OK;
		r.result_value = '0;
		count = shadow_values.size();
		pri = item.priority_req;
		case (item.opcode)
			odpi_pkg::OP_APPEND, odpi_pkg::OP_PREPEND, odpi_pkg::OP_INSERT: begin
				if (count >= DEPTH) begin
					r.status = odpi_pkg::ST_FULL;
				end else begin
					placed_pri = '0;
					if (item.opcode == odpi_pkg::OP_APPEND) begin
						pos = count;
					end else if (item.opcode == odpi_pkg::OP_PREPEND) begin
						pos = 0;
					end else begin
						placed_pri = pri;
						if (count == 0 || pri <= shadow_priorities[0]) begin
							pos = 0;
						end else if (pri >= shadow_priorities[count - 1]) begin
							pos = count;
						end else begin
							pos = 1;
							while (pos < count && pri > shadow_priorities[pos])
								pos++;
						end
					end
					if (pos == count) begin
						shadow_values.push_back(item.item_value);
						shadow_priorities.push_back(placed_pri);
					end else begin
						shadow_values.insert(pos, item.item_value);
						shadow_priorities.insert(pos, placed_pri);
					end
				end
			end
			odpi_pkg::OP_DEQUEUE, odpi_pkg::OP_PEEK: begin
				if (count == 0) begin
					r.status = odpi_pkg::ST_EMPTY;
				end else begin
					r.result_value = shadow_values[0];
					if (item.opcode == odpi_pkg::OP_DEQUEUE) begin
						void'(shadow_values.pop_front());
						void'(shadow_priorities.pop_front());
					end
				end
			end
			odpi_pkg::OP_DELETE: begin
				r.status = odpi_pkg::ST_NOTFOUND;
				for (pos = 0; pos < count; pos++) begin
					if (shadow_values[pos] == item.item_value) begin
						shadow_values.delete(pos);
						shadow_priorities.delete(pos);
						r.status = odpi_pkg::ST_OK;
						break;
					end
				end
			end
			default: begin
			end
		endcase
		r.entry_count = 5'(shadow_values.size());
		return r;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2, 3, 4: return $urandom_range(0, 7);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_item(input odpi_pkg::req_t item);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!(req_valid && !req_stall));
		pending_responses.push_back(deque_apply(item));
	endtask

	task automatic send_op(input logic [2:0] op, input logic [31:0] value,
			input logic signed [15:0] pri);
		odpi_pkg::req_t item;
		item.opcode = op;
		item.item_value = value;
		item.priority_req = pri;
		send_item(item);
	endtask

	always @(posedge clk) begin : check_responses
		odpi_pkg::rsp_t want;
		if (rsp_valid && !rsp_stall) begin
			if (pending_responses.size() == 0) begin
				$display("%0t: unexpected item, got %h", $time, rsp);
				mismatches++;
			end else begin
				want = pending_responses.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d, got %0d", $time, want.status, rsp.status);
					mismatches++;
				end
				if (rsp.result_value !== want.result_value) begin
					$display("%0t: result_value expected %h, got %h", $time,
						want.result_value, rsp.result_value);
					mismatches++;
				end
				if (rsp.entry_count !== want.entry_count) begin
					$display("%0t: entry_count expected %0d, got %0d", $time,
						want.entry_count, rsp.entry_count);
					mismatches++;
				end
			end
		end
	end

	task automatic test_empty_queue();
		send_op(odpi_pkg::OP_DEQUEUE, 32'h0000_0001, 16'sd0);
		send_op(odpi_pkg::OP_PEEK, 32'hFFFF_FFFF, -16'sd1);
		send_op(odpi_pkg::OP_DELETE, 32'h0000_0000, 16'sd0);
	endtask

	task automatic test_unused_opcodes();
		send_op(OP_RESERVED_6, 32'hFFFF_FFFF, 16'sh7FFF);
		send_op(OP_RESERVED_7, 32'h0000_0000, 16'sh8000);
	endtask

	task automatic test_priority_placement();
		send_op(odpi_pkg::OP_INSERT, 32'h0000_0010, 16'sd0);
		send_op(odpi_pkg::OP_INSERT, 32'h0000_0011, 16'sh7FFF);
		send_op(odpi_pkg::OP_INSERT, 32'h0000_0012, 16'sh8000);
		send_op(odpi_pkg::OP_INSERT, 32'h0000_0013, 16'sd100);
		send_op(odpi_pkg::OP_INSERT, 32'h0000_0014, 16'sd100);
		send_op(odpi_pkg::OP_INSERT, 32'h0000_0015, 16'sh7FFF);
		send_op(odpi_pkg::OP_APPEND, 32'hFFFF_FFFF, 16'sd5);
		send_op(odpi_pkg::OP_PREPEND, 32'h0000_0000, -16'sd5);
	endtask

	task automatic test_fill_to_full();
		while (shadow_values.size() < DEPTH)
			send_op(odpi_pkg::OP_APPEND, 32'hA5A5_0000 + shadow_values.size(), 16'sd0);
		send_op(odpi_pkg::OP_APPEND, 32'h1234_5678, 16'sd0);
		send_op(odpi_pkg::OP_PREPEND, 32'h1234_5678, 16'sd0);
		send_op(odpi_pkg::OP_INSERT, 32'h1234_5678, 16'sh8000);
	endtask

	task automatic test_drain_and_delete();
		send_op(odpi_pkg::OP_PEEK, 32'h0, 16'sd0);
		send_op(odpi_pkg::OP_DELETE, 32'h0000_0013, 16'sd0);
		send_op(odpi_pkg::OP_DELETE, 32'hDEAD_BEEF, 16'sd0);
		send_op(odpi_pkg::OP_DEQUEUE, 32'h0, 16'sd0);
	endtask

	task automatic test_random_traffic();
		int idle_mix[4] = '{0, 74, 0, 38};
		int stall_mix[4] = '{0, 0, 74, 38};
		int phase;
		int n;
		int roll;
		int add_limit;
		odpi_pkg::req_t item;
		for (phase = 0; phase < 4; phase++) begin
			sender_idle_pct = idle_mix[phase];
			rsp_stall_pct = stall_mix[phase];
			for (n = 0; n < 105; n++) begin
				if (n % 20 == 0)
					add_limit = $urandom_range(0, 1) ? 75 : 35;
				roll = $urandom_range(0, 99);
				item.item_value = pick_value();
				case ($urandom_range(0, 9))
					0: item.priority_req = 16'sh8000;
					1: item.priority_req = 16'sh7FFF;
					2, 3, 4, 5: item.priority_req = 16'($signed($urandom_range(0, 8)) - 4);
					default: item.priority_req = 16'($urandom());
				endcase
				if (roll < 4) begin
					item.opcode = $urandom_range(0, 1) ? OP_RESERVED_6 : OP_RESERVED_7;
				end else if (roll < add_limit) begin
					case ($urandom_range(0, 4))
						0: item.opcode = odpi_pkg::OP_APPEND;
						1: item.opcode = odpi_pkg::OP_PREPEND;
						default: item.opcode = odpi_pkg::OP_INSERT;
					endcase
				end else begin
					case ($urandom_range(0, 2))
						0: item.opcode = odpi_pkg::OP_DEQUEUE;
						1: item.opcode = odpi_pkg::OP_PEEK;
						default: begin
							item.opcode = odpi_pkg::OP_DELETE;
							if (shadow_values.size() != 0 && $urandom_range(0, 9) < 7)
								item.item_value = shadow_values[
									$urandom_range(0, shadow_values.size() - 1)];
						end
					endcase
				end
				send_item(item);
			end
		end
	endtask

	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("ordered_deque_with_priority_insert_unit regression: fail");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_unused_opcodes();
		test_priority_placement();
		test_fill_to_full();
		test_drain_and_delete();
		test_random_traffic();
		req_valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("ordered_deque_with_priority_insert_unit regression: pass");
		else
			$display("ordered_deque_with_priority_insert_unit regression: fail");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/odpi_pkg.sv
rtl/odpi_cell.sv
rtl/ordered_deque_with_priority_insert_unit.sv
rtl/odpi_checker.sv
test/ordered_deque_with_priority_insert_unit_tb.sv
